### design/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int CH_W     = 8;                // channel width
    localparam int HUE_FRAC = 6;                // hue fraction bits (1/64 degree)
    localparam int HUE_W    = HUE_FRAC + 9;     // 15-bit hue
    localparam int Q_W      = 12;               // quotient bits per divider (3840 < 4096)
    localparam int NUM_W    = 20;               // dividend width (3840*255 < 2^20)
    localparam int DSH_W    = CH_W + Q_W - 1;   // divisor aligned to top quotient bit
    localparam int IN_W     = 3 * CH_W;         // 24, already whole bytes
    localparam int OUT_W    = 32;               // 15 + 8 + 8 = 31, padded to bytes

    localparam logic [Q_W-1:0]   HUE_UNIT = 12'd3840;   // 60 degrees
    localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;  // 360 degrees

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // One restoring divider in flight
    typedef struct packed {
        logic [NUM_W-1:0] rem;   // partial remainder
        logic [DSH_W-1:0] dsh;   // divisor shifted to the current quotient bit
        logic [Q_W-1:0]   q;     // quotient bits so far
    } t_div;

    // Pixel context riding along the chain
    typedef struct packed {
        t_sector         sector;
        logic            neg;    // hue difference was negative
        logic            grey;   // all channels equal
        logic [CH_W-1:0] mx;
    } t_meta;

    typedef struct packed {
        logic  valid;
        t_div  hue;
        t_div  sat;
        t_meta meta;
    } t_stage;

endpackage

### design/rgbhsv_front.sv
// Input stage: max/min, hue sector, dividends and aligned divisors.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_front import rgbhsv_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output t_stage          o_stage
);

    logic [CH_W-1:0]  w_mx, w_mn, w_delta, w_dmag;
    logic [NUM_W-1:0] w_hnum;
    t_stage           n_stage, r_stage;

    always_comb begin
        w_mx = (i_red > i_green) ? i_red : i_green;
        w_mx = (w_mx > i_blue) ? w_mx : i_blue;
        w_mn = (i_red < i_green) ? i_red : i_green;
        w_mn = (w_mn < i_blue) ? w_mn : i_blue;
        w_delta = w_mx - w_mn;

        // sector priority: red, green, blue
        n_stage.meta.mx   = w_mx;
        n_stage.meta.grey = (w_delta == '0);
        if (i_red == w_mx) begin
            n_stage.meta.sector = SEC_RED;
            n_stage.meta.neg    = (i_green < i_blue);
            w_dmag = n_stage.meta.neg ? (i_blue - i_green) : (i_green - i_blue);
        end else if (i_green == w_mx) begin
            n_stage.meta.sector = SEC_GREEN;
            n_stage.meta.neg    = (i_blue < i_red);
            w_dmag = n_stage.meta.neg ? (i_red - i_blue) : (i_blue - i_red);
        end else begin
            n_stage.meta.sector = SEC_BLUE;
            n_stage.meta.neg    = (i_red < i_green);
            w_dmag = n_stage.meta.neg ? (i_green - i_red) : (i_red - i_green);
        end

        w_hnum = NUM_W'(w_dmag) * NUM_W'(HUE_UNIT);

        n_stage.valid   = i_valid;
        n_stage.hue.rem = w_hnum;
        n_stage.hue.dsh = DSH_W'(w_delta) << (Q_W - 1);
        n_stage.hue.q   = '0;
        // 255*delta as (delta << 8) - delta
        n_stage.sat.rem = NUM_W'({w_delta, {CH_W{1'b0}}}) - NUM_W'(w_delta);
        n_stage.sat.dsh = DSH_W'(w_mx) << (Q_W - 1);
        n_stage.sat.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.hue  <= n_stage.hue;
            r_stage.sat  <= n_stage.sat;
            r_stage.meta <= n_stage.meta;
        end
    end

    assign o_stage = r_stage;

endmodule

### design/rgbhsv_div_cell.sv
// One divider cell: resolves one quotient bit of the hue and of the
// saturation division, then hands the pixel to the next cell. Uses rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_div_cell import rgbhsv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage n_stage, r_stage;

    function automatic t_div div_step(input t_div d);
        t_div o;
        logic ge;
        ge    = (d.rem >= NUM_W'(d.dsh));
        o.rem = ge ? (d.rem - NUM_W'(d.dsh)) : d.rem;
        o.q   = {d.q[Q_W-2:0], ge};
        o.dsh = d.dsh >> 1;
        return o;
    endfunction

    always_comb begin
        n_stage       = i_stage;
        n_stage.hue   = div_step(i_stage.hue);
        n_stage.sat   = div_step(i_stage.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.hue  <= n_stage.hue;
            r_stage.sat  <= n_stage.sat;
            r_stage.meta <= n_stage.meta;
        end
    end

    assign o_stage = r_stage;

endmodule

### design/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: input stage, a row of divider
// cells and the output register. Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div_cell.
`timescale 1ns / 1ps

// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   red[7:0], green[15:8], blue[23:16]
// m_axis    out  hue[14:0], saturation[22:15], brightness[30:23], bit 31 zero
//
// One pixel per cycle sustained while m_axis is not stalled; the path is the input
// stage, 12 divider cells and the output register. The 12 cells each settle one quotient
// bit of both divisions, so the chain length sets the latency.
// i_rst_n is synchronous, active low, and empties every stage.
// A stall on m_axis freezes the whole chain; s_axis_tready drops only while
// the output register holds an item that is not taken.

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // red, green, blue
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // hue, saturation, brightness, pad
);

    logic               w_en;
    t_stage             w_chain [0:Q_W];
    logic               r_out_valid;
    logic [HUE_W-1:0]   r_hue, n_hue;
    logic [CH_W-1:0]    r_sat, n_sat;
    logic [CH_W-1:0]    r_val;
    logic [HUE_W:0]     w_sum;      // one extra bit for the sign
    logic [HUE_W-1:0]   w_off;
    logic               w_carry;
    t_stage             w_last;

    // whole chain moves together
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_red   (s_axis_tdata[CH_W-1:0]),
        .i_green (s_axis_tdata[2*CH_W-1:CH_W]),
        .i_blue  (s_axis_tdata[3*CH_W-1:2*CH_W]),
        .o_stage (w_chain[0])
    );

    // quotient bit Q_W-1 first, bit 0 last
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        rgbhsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign w_last = w_chain[Q_W];

    // Sector offset plus floor quotient; a negative difference rounds toward
    // minus infinity, and a negative total wraps by 360 degrees.
    always_comb begin
        case (w_last.meta.sector)
            SEC_RED:   w_off = '0;
            SEC_GREEN: w_off = HUE_W'({HUE_UNIT, 1'b0});
            SEC_BLUE:  w_off = HUE_W'({HUE_UNIT, 2'b00});
            default:   w_off = '0;
        endcase
        w_carry = |w_last.hue.rem;
        if (w_last.meta.neg) begin
            w_sum = (HUE_W+1)'(w_off) - (HUE_W+1)'(w_last.hue.q) - (HUE_W+1)'(w_carry);
        end else begin
            w_sum = (HUE_W+1)'(w_off) + (HUE_W+1)'(w_last.hue.q);
        end
        if (w_sum[HUE_W]) begin
            w_sum = w_sum + (HUE_W+1)'(HUE_FULL);
        end
        if (w_last.meta.grey) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = w_sum[HUE_W-1:0];
            n_sat = w_last.sat.q[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
        if (w_en) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= w_last.meta.mx;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_val, r_sat, r_hue};

    // hue always inside one turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_hue < HUE_FULL))
        else $error("hue out of range");

    // zero saturation only for grey pixels, which carry zero hue
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_sat == '0)) |-> (r_hue == '0))
        else $error("nonzero hue with zero saturation");

    // hue quotient never exceeds one sector
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last.valid && !w_last.meta.grey) |-> (w_last.hue.q <= HUE_UNIT))
        else $error("hue quotient overflow");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_hue)
                                             && $stable(r_sat) && $stable(r_val)))
        else $error("output changed under stall");

endmodule
